@@ hdl/mi_pkg.sv @@
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// Used by every module of the block; depends on nothing.
`default_nettype none
package mi_pkg;

    // Quotient bits produced by each divider lane (one extra for the saturation check).
    localparam int QBITS = 33;
    // Width of the exact signed determinant (Q48.48 plus guard bits).
    localparam int DET_W = 98;
    // Width of the determinant magnitude.
    localparam int MAG_W = 97;
    // Register stages from the input register to the front end's output.
    localparam int FRONT_STAGES = 7;
    // Register stages inside one divider lane.
    localparam int LANE_STAGES = QBITS + 1;
    localparam int PIPE_DEPTH = FRONT_STAGES + LANE_STAGES;

    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic signed [31:0] in_r0c0;
        logic signed [31:0] in_r0c1;
        logic signed [31:0] in_r0c2;
        logic signed [31:0] in_r1c0;
        logic signed [31:0] in_r1c1;
        logic signed [31:0] in_r1c2;
        logic signed [31:0] in_r2c0;
        logic signed [31:0] in_r2c1;
        logic signed [31:0] in_r2c2;
    } mi_in_t;

    typedef struct packed {
        logic signed [31:0] inv_r0c0;
        logic signed [31:0] inv_r0c1;
        logic signed [31:0] inv_r0c2;
        logic signed [31:0] inv_r1c0;
        logic signed [31:0] inv_r1c1;
        logic signed [31:0] inv_r1c2;
        logic signed [31:0] inv_r2c0;
        logic signed [31:0] inv_r2c1;
        logic signed [31:0] inv_r2c2;
        logic signed [31:0] determinant;
        logic               singular;
        logic               saturated;
    } mi_out_t;

    // Determinant results that travel beside the divider lanes.
    typedef struct packed {
        logic [31:0] det;
        logic        det_sat;
        logic        singular;
    } mi_det_info_t;

endpackage
`default_nettype wire

@@ hdl/mi_front.sv @@
// Front end of the matrix inverse: cofactors, exact determinant, rounded determinant.
// Depends on mi_pkg.
`default_nettype none
module mi_front (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire mi_pkg::mi_in_t                in_data,
    output logic signed [63:0]                 cof_out [0:8],
    output logic [mi_pkg::MAG_W-1:0]           dmag_out,
    output logic                               dneg_out,
    output mi_pkg::mi_det_info_t               det_info_out
);

    // Cofactor k is m[PA]*m[PB] - m[PC]*m[PD], with m flattened row by row.
    localparam int PA [0:8] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
    localparam int PB [0:8] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
    localparam int PC [0:8] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
    localparam int PD [0:8] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

    logic signed [31:0] in_arr [0:8];
    logic signed [31:0] m_reg [0:8];
    logic signed [63:0] pp_reg [0:8];
    logic signed [63:0] pq_reg [0:8];
    logic signed [31:0] row0_s2_reg [0:2];
    logic signed [31:0] row0_s3_reg [0:2];
    logic signed [63:0] cof_s3_reg [0:8];
    logic signed [63:0] cof_s4_reg [0:8];
    logic signed [63:0] cof_s5_reg [0:8];
    logic signed [63:0] cof_s6_reg [0:8];
    logic signed [63:0] cof_s7_reg [0:8];
    logic signed [63:0] ph_reg [0:2];
    logic signed [64:0] pl_reg [0:2];
    logic signed [mi_pkg::DET_W-1:0] term_reg [0:2];
    logic signed [mi_pkg::DET_W-1:0] det_reg;
    logic [mi_pkg::MAG_W-1:0] dmag_reg;
    logic dneg_reg;
    mi_pkg::mi_det_info_t det_info_reg;

    logic [mi_pkg::DET_W-1:0] dabs;
    logic [mi_pkg::MAG_W-1:0] dmag_next;
    logic [mi_pkg::DET_W-1:0] rd_sum;
    logic [65:0] rd;
    logic rd_sat;
    mi_pkg::mi_det_info_t det_info_next;

    assign in_arr = '{in_data.in_r0c0, in_data.in_r0c1, in_data.in_r0c2,
                      in_data.in_r1c0, in_data.in_r1c1, in_data.in_r1c2,
                      in_data.in_r2c0, in_data.in_r2c1, in_data.in_r2c2};

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg <= in_arr;
            for (int k = 0; k < 9; k++) begin
                pp_reg[k] <= m_reg[PA[k]] * m_reg[PB[k]];
                pq_reg[k] <= m_reg[PC[k]] * m_reg[PD[k]];
                cof_s3_reg[k] <= pp_reg[k] - pq_reg[k];
            end
            for (int c = 0; c < 3; c++) begin
                row0_s2_reg[c] <= m_reg[c];
                row0_s3_reg[c] <= row0_s2_reg[c];
                // Column c of row 0 meets cofactor adj[c][0], split into halves.
                ph_reg[c] <= $signed(cof_s3_reg[c*3][63:32]) * row0_s3_reg[c];
                pl_reg[c] <= $signed({1'b0, cof_s3_reg[c*3][31:0]}) * row0_s3_reg[c];
                term_reg[c] <= $signed({{2{ph_reg[c][63]}}, ph_reg[c], 32'd0})
                             + $signed({{33{pl_reg[c][64]}}, pl_reg[c]});
            end
            cof_s4_reg <= cof_s3_reg;
            cof_s5_reg <= cof_s4_reg;
            cof_s6_reg <= cof_s5_reg;
            cof_s7_reg <= cof_s6_reg;
            det_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            dmag_reg <= dmag_next;
            dneg_reg <= det_reg[mi_pkg::DET_W-1];
            det_info_reg <= det_info_next;
        end
    end

    // Magnitude, then round half away from zero to Q16.16 and clip.
    always_comb begin
        dabs = det_reg[mi_pkg::DET_W-1] ? (~det_reg + 1'b1) : det_reg;
        dmag_next = dabs[mi_pkg::MAG_W-1:0];
        rd_sum = {1'b0, dmag_next} + {{(mi_pkg::DET_W-32){1'b0}}, 32'h8000_0000};
        rd = rd_sum[mi_pkg::DET_W-1:32];
        rd_sat = det_reg[mi_pkg::DET_W-1] ? (rd > {34'd0, mi_pkg::NEG_LIMIT})
                                          : (rd > {34'd0, mi_pkg::POS_LIMIT});
        det_info_next.det_sat = rd_sat;
        det_info_next.singular = (det_reg == '0);
        if (rd_sat) begin
            det_info_next.det = det_reg[mi_pkg::DET_W-1] ? mi_pkg::NEG_LIMIT
                                                         : mi_pkg::POS_LIMIT;
        end else begin
            det_info_next.det = det_reg[mi_pkg::DET_W-1] ? (~rd[31:0] + 32'd1) : rd[31:0];
        end
    end

    assign cof_out = cof_s7_reg;
    assign dmag_out = dmag_reg;
    assign dneg_out = dneg_reg;
    assign det_info_out = det_info_reg;

endmodule
`default_nettype wire

@@ hdl/mi_lane.sv @@
// One divider lane: cofactor / determinant as a rounded, clipped Q16.16 value.
// Pipelined restoring division, one quotient bit per stage. Depends on mi_pkg.
`default_nettype none
module mi_lane (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [63:0]            cof,
    input  wire logic [mi_pkg::MAG_W-1:0]      dmag,
    input  wire logic                          dneg,
    output logic [31:0]                        inv,
    output logic                               sat
);

    localparam int QB = mi_pkg::QBITS;
    localparam int W = mi_pkg::DET_W;

    logic [W-1:0]  r_reg   [0:QB];
    logic [W-1:0]  den_reg [0:QB];
    logic [QB-1:0] low_reg [0:QB];
    logic [QB-1:0] q_reg   [0:QB];
    logic          neg_reg [0:QB];
    logic          ovf_reg [0:QB];

    logic [63:0] cm;
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic [W-1:0] t [1:QB];
    logic         ge [1:QB];
    logic [QB-1:0] q;
    logic neg;

    // Numerator is 2*|cof|*2^32 + |det|, denominator 2*|det|: rounds half away from zero.
    always_comb begin
        cm = cof[63] ? (~cof + 64'd1) : cof;
        num = {1'b0, cm, 33'd0} + {1'b0, dmag};
        den = {dmag, 1'b0};
        for (int k = 1; k <= QB; k++) begin
            t[k] = {r_reg[k-1][W-2:0], low_reg[k-1][QB-1]};
            ge[k] = (t[k] >= den_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0] <= {{QB{1'b0}}, num[W-1:QB]};
            den_reg[0] <= den;
            low_reg[0] <= num[QB-1:0];
            q_reg[0] <= '0;
            neg_reg[0] <= cof[63] ^ dneg;
            ovf_reg[0] <= ({{QB{1'b0}}, num[W-1:QB]} >= den);
            for (int k = 1; k <= QB; k++) begin
                r_reg[k] <= ge[k] ? (t[k] - den_reg[k-1]) : t[k];
                den_reg[k] <= den_reg[k-1];
                low_reg[k] <= {low_reg[k-1][QB-2:0], 1'b0};
                q_reg[k] <= {q_reg[k-1][QB-2:0], ge[k]};
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    always_comb begin
        q = q_reg[QB];
        neg = neg_reg[QB];
        sat = ovf_reg[QB] || (neg ? (q > {1'b0, mi_pkg::NEG_LIMIT})
                                  : (q > {1'b0, mi_pkg::POS_LIMIT}));
        if (sat) begin
            inv = neg ? mi_pkg::NEG_LIMIT : mi_pkg::POS_LIMIT;
        end else begin
            inv = neg ? (~q[31:0] + 32'd1) : q[31:0];
        end
    end

endmodule
`default_nettype wire

@@ hdl/matrix3x3_inverse.sv @@
// Top level of the 3x3 Q16.16 matrix inverse: front end, nine divider lanes, merge, output.
// Depends on mi_pkg, mi_front and mi_lane.
//
// Usage: one beat on the s_ channel carries a whole 3x3 matrix of signed Q16.16
// entries; one beat on the m_ channel carries its inverse, its determinant, a
// singular flag and a saturated flag. Every accepted matrix yields exactly one
// result beat, in order.
// The front end forms the nine cofactors and the exact determinant in seven
// stages. Nine divider lanes, one per inverse entry, then each divide a cofactor
// by the determinant, one quotient bit per stage (34 stages). A merge step
// combines the lanes' clip flags with the determinant's and zeroes the inverse
// of a singular matrix. Throughput is one matrix per cycle while s_ready is
// high: the lanes are fully pipelined.
// When the receiver stalls, the output register holds its beat and one more
// beat is caught in a skid register; only then does s_ready fall and the whole
// pipeline freeze. s_ready is a register output, so no combinational path runs
// from m_ready to s_ready.
// Reset (aresetn low, synchronous) empties the pipeline and the output side;
// no result beat is pending afterwards.
`default_nettype none
module matrix3x3_inverse (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire mi_pkg::mi_in_t   s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output mi_pkg::mi_out_t       m_data
);

    localparam int DEPTH = mi_pkg::PIPE_DEPTH;
    localparam int LDEPTH = mi_pkg::LANE_STAGES;

    logic en;
    logic vld_reg [0:DEPTH-1];
    mi_pkg::mi_det_info_t dinfo_reg [0:LDEPTH-1];

    logic signed [63:0] cof [0:8];
    logic [mi_pkg::MAG_W-1:0] dmag;
    logic dneg;
    mi_pkg::mi_det_info_t det_info;

    logic [31:0] inv [0:8];
    logic        lane_sat [0:8];

    mi_pkg::mi_out_t res;
    mi_pkg::mi_out_t skid_reg;
    mi_pkg::mi_out_t m_data_reg;
    logic skid_vld_reg;
    logic m_vld_reg;
    logic res_vld;

    // The pipeline moves whenever the skid register is free.
    assign en = !skid_vld_reg;
    assign s_ready = en;

    mi_front u_front (
        .aclk         (aclk),
        .en           (en),
        .in_data      (s_data),
        .cof_out      (cof),
        .dmag_out     (dmag),
        .dneg_out     (dneg),
        .det_info_out (det_info)
    );

    for (genvar g = 0; g < 9; g++) begin : g_lane
        mi_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .cof  (cof[g]),
            .dmag (dmag),
            .dneg (dneg),
            .inv  (inv[g]),
            .sat  (lane_sat[g])
        );
    end

    // Valid bits track the data through every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int i = 1; i < DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Determinant results ride alongside the lanes so they line up at the merge.
    always_ff @(posedge aclk) begin
        if (en) begin
            dinfo_reg[0] <= det_info;
            for (int i = 1; i < LDEPTH; i++) begin
                dinfo_reg[i] <= dinfo_reg[i-1];
            end
        end
    end

    // Merge: a singular matrix gives zero entries and never reports clipping.
    always_comb begin
        logic any_sat;
        logic sing;
        any_sat = dinfo_reg[LDEPTH-1].det_sat;
        sing = dinfo_reg[LDEPTH-1].singular;
        for (int k = 0; k < 9; k++) begin
            any_sat = any_sat | lane_sat[k];
        end
        res.inv_r0c0 = sing ? '0 : inv[0];
        res.inv_r0c1 = sing ? '0 : inv[1];
        res.inv_r0c2 = sing ? '0 : inv[2];
        res.inv_r1c0 = sing ? '0 : inv[3];
        res.inv_r1c1 = sing ? '0 : inv[4];
        res.inv_r1c2 = sing ? '0 : inv[5];
        res.inv_r2c0 = sing ? '0 : inv[6];
        res.inv_r2c1 = sing ? '0 : inv[7];
        res.inv_r2c2 = sing ? '0 : inv[8];
        res.determinant = dinfo_reg[LDEPTH-1].det;
        res.singular = sing;
        res.saturated = !sing && any_sat;
        res_vld = en && vld_reg[DEPTH-1];
    end

    // Output register with a one-beat skid behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (m_vld_reg && !m_ready) begin
            if (res_vld) begin
                skid_vld_reg <= 1'b1;
            end
        end else if (skid_vld_reg) begin
            m_vld_reg <= 1'b1;
            skid_vld_reg <= 1'b0;
        end else begin
            m_vld_reg <= res_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_vld_reg && !m_ready) begin
            if (res_vld) begin
                skid_reg <= res;
            end
        end else if (skid_vld_reg) begin
            m_data_reg <= skid_reg;
        end else if (res_vld) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data = m_data_reg;

endmodule
`default_nettype wire

@@ hdl/mi_checker.sv @@
// Port-level checks for matrix3x3_inverse, attached to it by a bind statement.
// Depends on mi_pkg and the top level's ports.
`default_nettype none
module mi_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire mi_pkg::mi_out_t m_data
);

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A singular matrix gives a zero determinant; the diagonal and corner inverse entries are checked for zero.
    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.singular |->
            m_data.determinant == 0 && m_data.inv_r0c0 == 0 && m_data.inv_r1c1 == 0
            && m_data.inv_r2c2 == 0 && m_data.inv_r0c2 == 0 && m_data.inv_r2c0 == 0)
        else $error("singular result with nonzero entries");

    // A singular result never reports clipping.
    a_sing_nosat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.singular |-> !m_data.saturated)
        else $error("singular result flagged as saturated");

    // Input side only stops while a result is held back.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no result pending");

endmodule

bind matrix3x3_inverse mi_checker u_mi_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
